@@ hdl/udp_pdt_pkg.sv @@
// ----------------------------------------------------------------------------
// UDP port demux table package
// Shared codes, constants and the command and status bundles that run
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package udp_pdt_pkg;

	localparam int DEF_ENTRIES      = 64;
	localparam int MIN_PACKET_BYTES = 28;
	localparam logic [15:0] EPH_START = 16'd49152;

	localparam int ADDR_W = 32;
	localparam int PORT_W = 16;
	localparam int SOCK_W = 8;
	localparam int LEN_W  = 16;
	localparam int STAT_W = 3;

	// Request kinds.
	localparam logic [1:0] KIND_BIND    = 2'd0;
	localparam logic [1:0] KIND_RELEASE = 2'd1;
	localparam logic [1:0] KIND_ALLOC   = 2'd2;
	localparam logic [1:0] KIND_RECV    = 2'd3;

	// Result status codes.
	localparam logic [2:0] STAT_OK          = 3'd0;
	localparam logic [2:0] STAT_IN_USE      = 3'd1;
	localparam logic [2:0] STAT_NOT_REG     = 3'd2;
	localparam logic [2:0] STAT_NO_LISTENER = 3'd3;
	localparam logic [2:0] STAT_TOO_SHORT   = 3'd4;
	localparam logic [2:0] STAT_FULL        = 3'd5;

	// Table write operations.
	localparam logic [1:0] WR_NONE   = 2'd0;
	localparam logic [1:0] WR_CLEAR  = 2'd1;
	localparam logic [1:0] WR_INSERT = 2'd2;
	localparam logic [1:0] WR_REMOVE = 2'd3;

	typedef struct packed {
		logic       load_req;
		logic       clr_scan;
		logic       rd_en;
		logic [1:0] wr_op;
		logic       ctr_inc;
		logic       res_load;
		logic [2:0] res_status;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       too_short;
		logic       free_found;
		logic       ex_hit;
		logic       wc_hit;
		logic       sock_eq;
		logic       cand_zero;
		logic       out_busy;
	} dp_stat_t;

	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] addr;
		logic [PORT_W-1:0] port;
		logic [SOCK_W-1:0] sock;
	} entry_t;

endpackage

@@ hdl/udp_port_demux_table.sv @@
// ----------------------------------------------------------------------------
// UDP port demux table
// Bind, release, ephemeral allocate and receive lookup over a table of keys.
// ----------------------------------------------------------------------------
// Requests enter on the s_ channel: s_tuser carries the kind, s_tdata the
// key address, key port, socket id and packet length. Each request yields
// exactly one item on the m_ channel with status, found socket and port.
// After reset the block runs a clearing pass over each location of the
// entry memory with s_tready low, then waits for requests.
// One request is handled at a time. The table memory has one read port, so
// every request scans all ENTRIES entries, one a cycle, then passes a drain
// state and a decide state; the result shows on m_tvalid and s_tready rises
// again in the same cycle, so a new request is taken once the last is done.
// An allocate whose candidate port is taken while a free entry remains
// steps the counter and scans again for each skipped candidate.
// Results wait in an output register, so a new request is taken while the
// previous result is still pending; if m_tready stays low, the next request
// holds its decision until the output register is free, and no item is lost.
// ----------------------------------------------------------------------------
module udp_port_demux_table #(
	parameter int ENTRIES = udp_pdt_pkg::DEF_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // key_addr[31:0], key_port[47:32], socket_id[55:48],
	                              // packet_length[71:56]
	input  logic [1:0]  s_tuser,  // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // status[2:0], found_socket[10:3], result_port[26:11],
	                              // zero fill [31:27]
);

	localparam int IDX_W = $clog2(ENTRIES);

	udp_pdt_pkg::dp_cmd_t  cmd;
	udp_pdt_pkg::dp_stat_t stat;
	logic [IDX_W-1:0]      seq_addr;

	udp_pdt_ctrl #(
		.ENTRIES(ENTRIES),
		.IDX_W  (IDX_W)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.stat    (stat),
		.cmd     (cmd),
		.seq_addr(seq_addr)
	);

	udp_pdt_dp #(
		.ENTRIES(ENTRIES),
		.IDX_W  (IDX_W)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.seq_addr (seq_addr),
		.stat     (stat),
		.in_kind  (s_tuser),
		.in_data  (s_tdata),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (m_tdata)
	);

endmodule

@@ hdl/udp_pdt_dp.sv @@
// ----------------------------------------------------------------------------
// UDP port demux table datapath
// Holds the request, the entry memory, the scan accumulators, the ephemeral
// port counter and the output register.
// ----------------------------------------------------------------------------
module udp_pdt_dp #(
	parameter int ENTRIES = udp_pdt_pkg::DEF_ENTRIES,
	parameter int IDX_W   = $clog2(ENTRIES)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  udp_pdt_pkg::dp_cmd_t cmd,
	input  logic [IDX_W-1:0]     seq_addr,
	output udp_pdt_pkg::dp_stat_t stat,
	input  logic [1:0]           in_kind,
	input  logic [71:0]          in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [31:0]          out_data
);

	logic [1:0]                     kind_q;
	logic [udp_pdt_pkg::ADDR_W-1:0] addr_q;
	logic [udp_pdt_pkg::PORT_W-1:0] port_q;
	logic [udp_pdt_pkg::SOCK_W-1:0] sock_q;
	logic                           short_q;
	logic [udp_pdt_pkg::PORT_W-1:0] ctr_q;

	udp_pdt_pkg::entry_t mem [ENTRIES];
	udp_pdt_pkg::entry_t rdata_s1;
	logic                rvld_s1;
	logic [IDX_W-1:0]    ridx_s1;

	logic                           free_found_q;
	logic [IDX_W-1:0]               free_idx_q;
	logic                           ex_hit_q;
	logic [IDX_W-1:0]               ex_idx_q;
	logic [udp_pdt_pkg::SOCK_W-1:0] ex_sock_q;
	logic                           wc_hit_q;
	logic [udp_pdt_pkg::SOCK_W-1:0] wc_sock_q;

	logic                           out_valid_q;
	logic [2:0]                     out_status_q;
	logic [udp_pdt_pkg::SOCK_W-1:0] out_found_q;
	logic [udp_pdt_pkg::PORT_W-1:0] out_port_q;

	logic [udp_pdt_pkg::ADDR_W-1:0] eff_addr;
	logic [udp_pdt_pkg::PORT_W-1:0] eff_port;
	logic                           is_alloc;
	logic                           ex_match;
	logic                           wc_match;
	logic                           wr_en;
	logic [IDX_W-1:0]               wr_addr;
	udp_pdt_pkg::entry_t            wr_data;
	logic [udp_pdt_pkg::SOCK_W-1:0] res_found;
	logic [udp_pdt_pkg::PORT_W-1:0] res_port;

	// Allocate probes the wildcard key of the current counter value.
	assign is_alloc = (kind_q == udp_pdt_pkg::KIND_ALLOC);
	assign eff_addr = is_alloc ? '0 : addr_q;
	assign eff_port = is_alloc ? ctr_q : port_q;

	assign ex_match = rvld_s1 && rdata_s1.valid &&
		(rdata_s1.addr == eff_addr) && (rdata_s1.port == eff_port);
	assign wc_match = rvld_s1 && rdata_s1.valid &&
		(rdata_s1.addr == '0) && (rdata_s1.port == port_q);

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			kind_q  <= in_kind;
			addr_q  <= in_data[31:0];
			port_q  <= in_data[47:32];
			sock_q  <= in_data[55:48];
			short_q <= in_data[71:56] < 16'(udp_pdt_pkg::MIN_PACKET_BYTES);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= udp_pdt_pkg::EPH_START;
		end else if (cmd.ctr_inc) begin
			ctr_q <= ctr_q + 16'd1;
		end
	end

	always_comb begin
		wr_en   = 1'b1;
		wr_addr = seq_addr;
		wr_data = '0;
		case (cmd.wr_op)
			udp_pdt_pkg::WR_CLEAR: begin
				wr_addr = seq_addr;
			end
			udp_pdt_pkg::WR_INSERT: begin
				wr_addr       = free_idx_q;
				wr_data.valid = 1'b1;
				wr_data.addr  = eff_addr;
				wr_data.port  = eff_port;
				wr_data.sock  = sock_q;
			end
			udp_pdt_pkg::WR_REMOVE: begin
				wr_addr = ex_idx_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_s1 <= mem[seq_addr];
		end
		ridx_s1 <= seq_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_s1 <= 1'b0;
		end else begin
			rvld_s1 <= cmd.rd_en;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_found_q <= 1'b0;
			ex_hit_q     <= 1'b0;
			wc_hit_q     <= 1'b0;
		end else if (cmd.clr_scan) begin
			free_found_q <= 1'b0;
			ex_hit_q     <= 1'b0;
			wc_hit_q     <= 1'b0;
		end else begin
			if (rvld_s1 && !rdata_s1.valid && !free_found_q) begin
				free_found_q <= 1'b1;
			end
			if (ex_match) begin
				ex_hit_q <= 1'b1;
			end
			if (wc_match) begin
				wc_hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rvld_s1 && !rdata_s1.valid && !free_found_q) begin
			free_idx_q <= ridx_s1;
		end
		if (ex_match) begin
			ex_idx_q  <= ridx_s1;
			ex_sock_q <= rdata_s1.sock;
		end
		if (wc_match) begin
			wc_sock_q <= rdata_s1.sock;
		end
	end

	always_comb begin
		res_found = '0;
		if (kind_q == udp_pdt_pkg::KIND_RECV && cmd.res_status == udp_pdt_pkg::STAT_OK) begin
			res_found = ex_hit_q ? ex_sock_q : wc_sock_q;
		end
		res_port = port_q;
		if (is_alloc && cmd.res_status != udp_pdt_pkg::STAT_FULL) begin
			res_port = ctr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_status_q <= cmd.res_status;
			out_found_q  <= res_found;
			out_port_q   <= res_port;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {5'd0, out_port_q, out_found_q, out_status_q};

	assign stat.kind       = kind_q;
	assign stat.too_short  = short_q;
	assign stat.free_found = free_found_q;
	assign stat.ex_hit     = ex_hit_q;
	assign stat.wc_hit     = wc_hit_q;
	assign stat.sock_eq    = (ex_sock_q == sock_q);
	assign stat.cand_zero  = (ctr_q == '0);
	assign stat.out_busy   = out_valid_q && !out_ready;

endmodule

@@ hdl/udp_pdt_ctrl.sv @@
// ----------------------------------------------------------------------------
// UDP port demux table controller
// Sequences the clearing pass, the table scans and the final decision of
// each request.
// ----------------------------------------------------------------------------
module udp_pdt_ctrl #(
	parameter int ENTRIES = udp_pdt_pkg::DEF_ENTRIES,
	parameter int IDX_W   = $clog2(ENTRIES)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  udp_pdt_pkg::dp_stat_t stat,
	output udp_pdt_pkg::dp_cmd_t  cmd,
	output logic [IDX_W-1:0]      seq_addr
);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_DRAIN  = 3'd3;
	localparam logic [2:0] S_DECIDE = 3'd4;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	logic [2:0]       state_q;
	logic [2:0]       state_d;
	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] cnt_d;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.wr_op = udp_pdt_pkg::WR_CLEAR;
				if (cnt_q == LAST_IDX) begin
					cnt_d   = '0;
					state_d = S_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					cmd.clr_scan = 1'b1;
					cnt_d        = '0;
					state_d      = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.rd_en = 1'b1;
				if (cnt_q == LAST_IDX) begin
					state_d = S_DRAIN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_DRAIN: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (stat.kind == udp_pdt_pkg::KIND_ALLOC && stat.free_found && stat.ex_hit) begin
					// The candidate port is taken: step the counter and probe again.
					cmd.ctr_inc  = 1'b1;
					cmd.clr_scan = 1'b1;
					cnt_d        = '0;
					state_d      = S_SCAN;
				end else if (!stat.out_busy) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
					case (stat.kind)
						udp_pdt_pkg::KIND_BIND: begin
							if (stat.ex_hit) begin
								cmd.res_status = udp_pdt_pkg::STAT_IN_USE;
							end else if (!stat.free_found) begin
								cmd.res_status = udp_pdt_pkg::STAT_FULL;
							end else begin
								cmd.res_status = udp_pdt_pkg::STAT_OK;
								cmd.wr_op      = udp_pdt_pkg::WR_INSERT;
							end
						end
						udp_pdt_pkg::KIND_RELEASE: begin
							if (!stat.ex_hit) begin
								cmd.res_status = udp_pdt_pkg::STAT_NOT_REG;
							end else begin
								cmd.res_status = udp_pdt_pkg::STAT_OK;
								if (stat.sock_eq) begin
									cmd.wr_op = udp_pdt_pkg::WR_REMOVE;
								end
							end
						end
						udp_pdt_pkg::KIND_ALLOC: begin
							if (!stat.free_found) begin
								cmd.res_status = udp_pdt_pkg::STAT_FULL;
							end else begin
								cmd.ctr_inc = 1'b1;
								if (stat.cand_zero) begin
									cmd.res_status = udp_pdt_pkg::STAT_IN_USE;
								end else begin
									cmd.res_status = udp_pdt_pkg::STAT_OK;
									cmd.wr_op      = udp_pdt_pkg::WR_INSERT;
								end
							end
						end
						default: begin
							if (stat.too_short) begin
								cmd.res_status = udp_pdt_pkg::STAT_TOO_SHORT;
							end else if (stat.ex_hit || stat.wc_hit) begin
								cmd.res_status = udp_pdt_pkg::STAT_OK;
							end else begin
								cmd.res_status = udp_pdt_pkg::STAT_NO_LISTENER;
							end
						end
					endcase
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	assign seq_addr = cnt_q;

	a_insert_needs_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_op == udp_pdt_pkg::WR_INSERT |-> stat.free_found && !stat.ex_hit)
		else $error("insert issued without a free slot or with the key present");

	a_remove_needs_owner: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_op == udp_pdt_pkg::WR_REMOVE |-> stat.ex_hit && stat.sock_eq)
		else $error("remove issued for an entry not held by the socket");

	a_no_overwrite_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> !stat.out_busy)
		else $error("result loaded while the output item is still pending");

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_SCAN && cnt_q == '0)
		else $error("accepted item did not start a table scan");

	a_counter_only_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ctr_inc |-> stat.kind == udp_pdt_pkg::KIND_ALLOC && stat.free_found)
		else $error("ephemeral counter stepped outside an allocate");

endmodule
